[src/gjk_pkg.sv]
`default_nettype none
package gjk_pkg;

   localparam int COORD_W   = 16;
   localparam int MAX_PTS   = 4;
   localparam int BIG_W     = 56;
   localparam int SMALL_W   = 18;
   localparam int PROD_W    = BIG_W + SMALL_W;
   localparam int ACC_W     = 80;
   localparam int CROSS_LAST = 5;
   localparam int DOT_LAST   = 2;

   typedef struct packed {
      logic signed [63:0] z;
      logic signed [63:0] y;
      logic signed [63:0] x;
   } vec_type;

   typedef struct packed {
      logic start;
      logic is_dot;
      logic big_y;
   } mac_ctl_type;

   typedef enum logic [2:0] {
      SRC_AB, SRC_AC, SRC_AD, SRC_AO, SRC_T0, SRC_T1, SRC_E
   } src_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TET_F1, ST_TET_D1, ST_TET_F2, ST_TET_D2, ST_TET_F3, ST_TET_D3,
      ST_TRI_N, ST_TRI_C1, ST_TRI_D1, ST_TRI_DAC, ST_TRI_C2, ST_TRI_D2, ST_TRI_DN,
      ST_AB_D, ST_EP_1, ST_EP_2, ST_DONE
   } state_type;

   // component i of a vector
   function automatic logic signed [63:0] comp(input vec_type v, input logic [1:0] i);
      case (i)
         2'd0:    comp = v.x;
         2'd1:    comp = v.y;
         default: comp = v.z;
      endcase
   endfunction

endpackage
`default_nettype wire

[src/gjk_mac.sv]
`default_nettype none
// Shared multiply-accumulate unit: one product per cycle, registered before
// the accumulator. Cross product takes 6 products, dot product 3.
module gjk_mac import gjk_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mac_ctl_type ctl,
   input  wire vec_type     op_x,
   input  wire vec_type     op_y,
   output logic             done,
   output vec_type          result,
   output logic             pos_flag
);

   logic                      run_ff, run_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic                      pv_ff;
   logic [2:0]                ps_ff;
   logic                      dot_ff, big_y_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   vec_type                   res_ff;
   logic                      flag_ff;
   logic                      done_ff;

   logic                      is_dot, big_y;
   logic [2:0]                step;
   logic [1:0]                ci, cj, ck, xi, yi;
   logic signed [63:0]        xa, ya, big_v, small_v;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   prod_ext, acc_sum, acc_dif;
   logic [2:0]                last;

   assign is_dot = ctl.start ? ctl.is_dot : dot_ff;
   assign big_y  = ctl.start ? ctl.big_y  : big_y_ff;
   assign last   = dot_ff ? 3'(DOT_LAST) : 3'(CROSS_LAST);
   // step 0 is issued in the start cycle
   assign step   = ctl.start ? 3'd0 : cnt_ff;

   // operand index selection for the current step
   always_comb begin
      ci = step[2:1];
      case (ci)
         2'd0:    begin cj = 2'd1; ck = 2'd2; end
         2'd1:    begin cj = 2'd2; ck = 2'd0; end
         default: begin cj = 2'd0; ck = 2'd1; end
      endcase
      if (is_dot) begin
         xi = step[1:0];
         yi = step[1:0];
      end else if (!step[0]) begin
         xi = cj;
         yi = ck;
      end else begin
         xi = ck;
         yi = cj;
      end
      xa      = comp(op_x, xi);
      ya      = comp(op_y, yi);
      big_v   = big_y ? ya : xa;
      small_v = big_y ? xa : ya;
      prod    = PROD_W'(signed'(big_v[BIG_W-1:0]) * signed'(small_v[SMALL_W-1:0]));
   end

   assign prod_ext = ACC_W'(prod_ff);
   assign acc_sum  = ((ps_ff == 3'd0) ? '0 : acc_ff) + prod_ext;
   assign acc_dif  = acc_ff - prod_ext;

   // step counter
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = 3'd1;
      end else if (run_ff) begin
         if (cnt_ff == last) run_in = 1'b0;
         else cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= ctl.start ? 3'd1 : cnt_in;
         pv_ff   <= ctl.start || run_ff;
         done_ff <= pv_ff && ps_ff == last;
      end
   end

   // payload: product register, accumulator, results
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         dot_ff   <= ctl.is_dot;
         big_y_ff <= ctl.big_y;
      end
      if (ctl.start || run_ff) begin
         prod_ff <= prod;
         ps_ff   <= ctl.start ? 3'd0 : cnt_ff;
      end
      if (pv_ff) begin
         if (dot_ff) begin
            acc_ff <= acc_sum;
            if (ps_ff == 3'(DOT_LAST))
               flag_ff <= (acc_sum > 0);
         end else if (!ps_ff[0]) begin
            acc_ff <= prod_ext;
         end else begin
            case (ps_ff[2:1])
               2'd0:    res_ff.x <= acc_dif[63:0];
               2'd1:    res_ff.y <= acc_dif[63:0];
               default: res_ff.z <= acc_dif[63:0];
            endcase
         end
      end
   end

   assign done     = done_ff;
   assign result   = res_ff;
   assign pos_flag = flag_ff;

endmodule
`default_nettype wire

[src/gjk_simplex_update.sv]
`default_nettype none
// GJK simplex update for 3-D collision queries.
// Input stream req_*: one support point per transfer; req_tuser = 1 starts a
// new query with that point, 0 adds it to the simplex and steps.
// Result stream rsp_*: one transfer per input with the next search direction,
// the origin-enclosed flag and the simplex size.
// Each item runs through a sequencer that drives one shared multiply-
// accumulate unit through a chain of cross and dot product states. Start
// items and one-point steps go straight to the result; line, triangle and
// tetrahedron steps run their chain of dependent products, and this chain
// sets the rate. The next input can be taken in the cycle after the result
// is loaded.
// One item is processed at a time; req_tready is high while the sequencer is
// idle, also while a finished result still waits in the output register.
// If the receiver stalls, the next result waits until the output register is
// free. Reset empties the simplex and drops any pending result.
module gjk_simplex_update import gjk_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // point_x [15:0], point_y [31:16], point_z [47:32]
   input  wire logic [47:0]  req_tdata,
   // kind [0]
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // dir_x [63:0], dir_y [127:64], dir_z [191:128], contains_origin [192],
   // simplex_size [195:193], zero [199:196]
   output logic [199:0]      rsp_tdata
);

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } pt_type;

   state_type  state_ff, state_in;
   logic       go_ff;
   pt_type     pts_ff [MAX_PTS];
   pt_type     tri_b_ff, tri_c_ff;
   logic [2:0] count_ff;
   logic       ep_ac_ff;
   logic       inside_ff;
   vec_type    dir_ff, t0_ff, t1_ff;
   logic       rsp_valid_ff;
   logic [199:0] rsp_data_ff;

   pt_type      p;
   vec_type     ab, ac, ad, ao, op_x, op_y, mres;
   src_type     xsel, ysel;
   mac_ctl_type ctl;
   logic        is_op, mdone, mflag, accept, out_free;
   logic [2:0]  new_count;

   function automatic vec_type vdiff(input pt_type u, input pt_type v);
      vec_type r;
      r.x = 64'(u.x) - 64'(v.x);
      r.y = 64'(u.y) - 64'(v.y);
      r.z = 64'(u.z) - 64'(v.z);
      return r;
   endfunction

   function automatic vec_type vneg(input vec_type v);
      vec_type r;
      r.x = -v.x;
      r.y = -v.y;
      r.z = -v.z;
      return r;
   endfunction

   assign p.x = req_tdata[15:0];
   assign p.y = req_tdata[31:16];
   assign p.z = req_tdata[47:32];

   assign ab = vdiff(tri_b_ff, pts_ff[0]);
   assign ac = vdiff(tri_c_ff, pts_ff[0]);
   assign ad = vdiff(pts_ff[3], pts_ff[0]);
   assign ao = vdiff('0, pts_ff[0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign new_count  = (count_ff >= 3'(MAX_PTS)) ? 3'(MAX_PTS) : count_ff + 3'd1;

   // operation issued by each state
   always_comb begin
      is_op = 1'b1;
      xsel  = SRC_AB;
      ysel  = SRC_AC;
      ctl.is_dot = 1'b0;
      ctl.big_y  = 1'b0;
      case (state_ff)
         ST_TET_F1:  begin xsel = SRC_AB; ysel = SRC_AC; end
         ST_TET_F2:  begin xsel = SRC_AC; ysel = SRC_AD; end
         ST_TET_F3:  begin xsel = SRC_AD; ysel = SRC_AB; end
         ST_TET_D1, ST_TET_D2, ST_TET_D3, ST_TRI_DN: begin
            xsel = SRC_T0; ysel = SRC_AO; ctl.is_dot = 1'b1;
         end
         ST_TRI_N:   begin xsel = SRC_AB; ysel = SRC_AC; end
         ST_TRI_C1:  begin xsel = SRC_T0; ysel = SRC_AC; end
         ST_TRI_D1, ST_TRI_D2: begin
            xsel = SRC_T1; ysel = SRC_AO; ctl.is_dot = 1'b1;
         end
         ST_TRI_DAC: begin xsel = SRC_AC; ysel = SRC_AO; ctl.is_dot = 1'b1; end
         ST_TRI_C2:  begin xsel = SRC_AB; ysel = SRC_T0; ctl.big_y = 1'b1; end
         ST_AB_D:    begin xsel = SRC_AB; ysel = SRC_AO; ctl.is_dot = 1'b1; end
         ST_EP_1:    begin xsel = SRC_E;  ysel = SRC_AO; end
         ST_EP_2:    begin xsel = SRC_T1; ysel = SRC_E;  end
         default:    is_op = 1'b0;
      endcase
      ctl.start = is_op && go_ff;
   end

   function automatic vec_type pick(input src_type s, input vec_type vab,
         input vec_type vac, input vec_type vad, input vec_type vao,
         input vec_type v0, input vec_type v1, input logic e_ac);
      case (s)
         SRC_AB:  pick = vab;
         SRC_AC:  pick = vac;
         SRC_AD:  pick = vad;
         SRC_AO:  pick = vao;
         SRC_T0:  pick = v0;
         SRC_T1:  pick = v1;
         default: pick = e_ac ? vac : vab;
      endcase
   endfunction

   assign op_x = pick(xsel, ab, ac, ad, ao, t0_ff, t1_ff, ep_ac_ff);
   assign op_y = pick(ysel, ab, ac, ad, ao, t0_ff, t1_ff, ep_ac_ff);

   gjk_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .op_x     (op_x),
      .op_y     (op_y),
      .done     (mdone),
      .result   (mres),
      .pos_flag (mflag)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) state_in = ST_DONE;
               else begin
                  case (new_count)
                     3'd2:    state_in = ST_AB_D;
                     3'd3:    state_in = ST_TRI_N;
                     3'd4:    state_in = ST_TET_F1;
                     default: state_in = ST_DONE;
                  endcase
               end
            end
         end
         ST_TET_F1:  if (mdone) state_in = ST_TET_D1;
         ST_TET_D1:  if (mdone) state_in = mflag ? ST_TRI_N : ST_TET_F2;
         ST_TET_F2:  if (mdone) state_in = ST_TET_D2;
         ST_TET_D2:  if (mdone) state_in = mflag ? ST_TRI_N : ST_TET_F3;
         ST_TET_F3:  if (mdone) state_in = ST_TET_D3;
         ST_TET_D3:  if (mdone) state_in = mflag ? ST_TRI_N : ST_DONE;
         ST_TRI_N:   if (mdone) state_in = ST_TRI_C1;
         ST_TRI_C1:  if (mdone) state_in = ST_TRI_D1;
         ST_TRI_D1:  if (mdone) state_in = mflag ? ST_TRI_DAC : ST_TRI_C2;
         ST_TRI_DAC: if (mdone) state_in = mflag ? ST_EP_1 : ST_AB_D;
         ST_TRI_C2:  if (mdone) state_in = ST_TRI_D2;
         ST_TRI_D2:  if (mdone) state_in = mflag ? ST_AB_D : ST_TRI_DN;
         ST_TRI_DN:  if (mdone) state_in = ST_DONE;
         ST_AB_D:    if (mdone) state_in = mflag ? ST_EP_1 : ST_DONE;
         ST_EP_1:    if (mdone) state_in = ST_EP_2;
         ST_EP_2:    if (mdone) state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= (state_in != state_ff);
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         // simplex size
         if (accept) count_ff <= req_tuser ? 3'd1 : new_count;
         else if (mdone) begin
            case (state_ff)
               ST_TRI_DAC: count_ff <= mflag ? 3'd2 : count_ff;
               ST_TRI_DN:  count_ff <= 3'd3;
               ST_AB_D:    count_ff <= mflag ? 3'd2 : 3'd1;
               default:    count_ff <= count_ff;
            endcase
         end
      end
   end

   // simplex points and datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         inside_ff <= 1'b0;
         dir_ff    <= vneg(vdiff(p, '0));
         pts_ff[0] <= p;
         if (!req_tuser) begin
            pts_ff[1] <= pts_ff[0];
            pts_ff[2] <= pts_ff[1];
            pts_ff[3] <= pts_ff[2];
            tri_b_ff  <= pts_ff[0];
            tri_c_ff  <= pts_ff[1];
         end
      end
      if (mdone) begin
         case (state_ff)
            ST_TET_F1, ST_TET_F2, ST_TET_F3, ST_TRI_N: t0_ff <= mres;
            ST_TRI_C1, ST_TRI_C2, ST_EP_1:             t1_ff <= mres;
            ST_TET_D1: ;
            ST_TET_D2: if (mflag) begin
               tri_b_ff <= pts_ff[2];
               tri_c_ff <= pts_ff[3];
            end
            ST_TET_D3: begin
               if (mflag) begin
                  tri_b_ff <= pts_ff[3];
                  tri_c_ff <= pts_ff[1];
               end else begin
                  inside_ff <= 1'b1;
                  dir_ff    <= '0;
               end
            end
            ST_TRI_DAC: if (mflag) begin
               pts_ff[1] <= tri_c_ff;
               ep_ac_ff  <= 1'b1;
            end
            ST_TRI_DN: begin
               if (mflag) begin
                  pts_ff[1] <= tri_b_ff;
                  pts_ff[2] <= tri_c_ff;
                  dir_ff    <= t0_ff;
               end else begin
                  pts_ff[1] <= tri_c_ff;
                  pts_ff[2] <= tri_b_ff;
                  dir_ff    <= vneg(t0_ff);
               end
            end
            ST_AB_D: begin
               if (mflag) begin
                  pts_ff[1] <= tri_b_ff;
                  ep_ac_ff  <= 1'b0;
               end else begin
                  dir_ff <= ao;
               end
            end
            ST_EP_2: dir_ff <= mres;
            default: ;
         endcase
      end
      if (state_ff == ST_DONE && out_free)
         rsp_data_ff <= {4'd0, count_ff, inside_ff, dir_ff.z, dir_ff.y, dir_ff.x};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
